/* sv/wmc_pkg.sv */
`timescale 1ns / 1ps

package wmc_pkg;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_ABSENT    = 2'd1;
   localparam logic [1:0] STATUS_SPAN      = 2'd2;
   localparam logic [1:0] STATUS_SATURATED = 2'd3;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [15:0]        occurrences;
      logic [31:0]        total_held;
      logic               is_empty;
      logic signed [31:0] min_value;
      logic signed [31:0] max_value;
      logic [1:0]         status;
   } rsp_type;

endpackage

/* sv/wmc_stream_if.sv */
`timescale 1ns / 1ps

interface wmc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* sv/wmc_ram.sv */
`timescale 1ns / 1ps

module wmc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* sv/windowed_multiset_counter.sv */
`timescale 1ns / 1ps

// Windowed multiset counter: occurrence counts of signed 32-bit values.
// req_chan (sink) carries transactions {op, value}: add, remove or query.
// rsp_chan (source) returns one transaction per request with the value's
// count, the total held, emptiness, the current bounds and a status.
// Add, query and a plain remove go through the multiply, read and update
// states; the next request is taken in the update state as the result is
// registered. The count memory slot is the offset-binary code of value
// mod DEPTH, found by two registered multiplies and a correction before
// the single memory read; the update is written back from the update
// state. A remove that empties the smallest or largest value scans the
// count memory one entry per cycle and answers from a final state; the
// next request waits for idle. After reset the count memory is zeroed,
// one entry per cycle, before any request; bounds and total reset to zero.
// The result sits in an output register, so a stalled receiver does not
// hold up the next request; an update waits only if that register is full.
module windowed_multiset_counter #(
   parameter int DEPTH      = 1024,
   parameter int COUNT_BITS = 16
) (
   input logic         clock,
   input logic         reset,
   wmc_stream_if.sink   req_chan,
   wmc_stream_if.source rsp_chan
);
   localparam int SLOT_BITS = $clog2(DEPTH);
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(DEPTH));
   localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_MUL1  = 8'b0000_0100,
      S_MUL2  = 8'b0000_1000,
      S_READ  = 8'b0001_0000,
      S_UPD   = 8'b0010_0000,
      S_SCAN  = 8'b0100_0000,
      S_FIN   = 8'b1000_0000
   } state_type;

   function automatic logic [SLOT_BITS-1:0] slot_next(input logic [SLOT_BITS-1:0] s,
                                                      input logic up);
      logic [SLOT_BITS-1:0] r;
      if (up) begin
         r = (s == SLOT_LAST) ? '0 : s + SLOT_BITS'(1);
      end else begin
         r = (s == '0) ? SLOT_LAST : s - SLOT_BITS'(1);
      end
      return r;
   endfunction

   state_type            state_ff, state_in;
   logic [SLOT_BITS-1:0] clr_ff, clr_in;
   logic [1:0]           op_ff, op_in;
   logic signed [31:0]   value_ff, value_in;
   logic [31:0]          quot_ff, quot_in;
   logic [31:0]          qd_ff, qd_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic signed [31:0]   lo_ff, lo_in;
   logic signed [31:0]   hi_ff, hi_in;
   logic [31:0]          total_ff, total_in;
   logic signed [31:0]   p_ff, p_in;
   logic [SLOT_BITS-1:0] pslot_ff, pslot_in;
   logic                 scan_up_ff, scan_up_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   wmc_pkg::rsp_type     rsp_ff, rsp_in;

   logic                  wr_en;
   logic [SLOT_BITS-1:0]  wr_addr, rd_addr;
   logic [COUNT_BITS-1:0] wr_data, rd_data;
   logic                  req_ready;

   logic [31:0]           code;
   logic [63:0]           prod;
   logic [63:0]           qd;
   logic [31:0]           rem, rem_fix;
   logic [SLOT_BITS-1:0]  slot_calc;
   logic                  out_free;
   logic                  scan_stop;

   // update-stage results
   logic [COUNT_BITS-1:0] cnt, cnt_eff;
   logic                  empty, in_window, too_wide;
   logic signed [31:0]    nlo, nhi;
   logic [32:0]           span;
   logic                  u_ok, u_wr, u_scan, u_scan_up;
   logic [1:0]            u_status;
   logic [COUNT_BITS-1:0] u_occ, u_wdata;
   logic signed [31:0]    u_lo, u_hi;
   logic [31:0]           u_total;

   wmc_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (DEPTH)
   ) u_counts (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // slot = offset-binary code mod DEPTH via reciprocal; estimate is low by at most one
   assign code      = {~value_ff[31], value_ff[30:0]};
   assign prod      = 64'(code) * 64'(RECIP);
   assign qd        = 64'(quot_ff) * 64'(DEPTH);
   assign rem       = code - qd_ff;
   assign rem_fix   = (rem >= 32'(DEPTH)) ? rem - 32'(DEPTH) : rem;
   assign slot_calc = rem_fix[SLOT_BITS-1:0];

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign scan_stop = (p_ff == (scan_up_ff ? hi_ff : lo_ff)) || (rd_data != '0);

   assign cnt       = rd_data;
   assign empty     = (total_ff == '0);
   assign in_window = !empty && (value_ff >= lo_ff) && (value_ff <= hi_ff);
   assign cnt_eff   = in_window ? cnt : '0;
   assign nlo       = (value_ff < lo_ff) ? value_ff : lo_ff;
   assign nhi       = (value_ff > hi_ff) ? value_ff : hi_ff;
   assign span      = {nhi[31], nhi} - {nlo[31], nlo};
   assign too_wide  = (span >= 33'(DEPTH - 1));

   always_comb begin
      u_ok      = 1'b0;
      u_status  = wmc_pkg::STATUS_ABSENT;
      u_occ     = '0;
      u_wr      = 1'b0;
      u_wdata   = cnt;
      u_lo      = lo_ff;
      u_hi      = hi_ff;
      u_total   = total_ff;
      u_scan    = 1'b0;
      u_scan_up = 1'b0;
      priority if (op_ff == wmc_pkg::OP_ADD) begin
         priority if (empty) begin
            u_wr     = 1'b1;
            u_wdata  = COUNT_BITS'(1);
            u_lo     = value_ff;
            u_hi     = value_ff;
            u_total  = 32'd1;
            u_ok     = 1'b1;
            u_status = wmc_pkg::STATUS_OK;
            u_occ    = COUNT_BITS'(1);
         end else if (too_wide) begin
            u_status = wmc_pkg::STATUS_SPAN;
         end else if (cnt_eff == COUNT_MAX) begin
            u_status = wmc_pkg::STATUS_SATURATED;
            u_occ    = cnt_eff;
         end else begin
            u_wr     = 1'b1;
            u_wdata  = cnt_eff + COUNT_BITS'(1);
            u_lo     = nlo;
            u_hi     = nhi;
            u_total  = (total_ff == '1) ? total_ff : total_ff + 32'd1;
            u_ok     = 1'b1;
            u_status = wmc_pkg::STATUS_OK;
            u_occ    = cnt_eff + COUNT_BITS'(1);
         end
      end else if (op_ff == wmc_pkg::OP_REMOVE) begin
         if (in_window && cnt != '0) begin
            u_wr     = 1'b1;
            u_wdata  = cnt - COUNT_BITS'(1);
            u_total  = (total_ff == '1) ? total_ff : total_ff - 32'd1;
            u_occ    = cnt - COUNT_BITS'(1);
            u_ok     = 1'b1;
            u_status = wmc_pkg::STATUS_OK;
            if (cnt == COUNT_BITS'(1)) begin
               priority if (lo_ff == hi_ff) begin
                  u_total = '0;
                  u_lo    = '0;
                  u_hi    = '0;
               end else if (value_ff == lo_ff) begin
                  u_scan    = 1'b1;
                  u_scan_up = 1'b1;
               end else if (value_ff == hi_ff) begin
                  u_scan    = 1'b1;
                  u_scan_up = 1'b0;
               end else begin
                  u_scan = 1'b0;
               end
            end
         end
      end else begin
         if (in_window && cnt != '0) begin
            u_ok     = 1'b1;
            u_status = wmc_pkg::STATUS_OK;
            u_occ    = cnt;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      quot_in      = prod[63:32];
      qd_in        = qd[31:0];
      slot_in      = slot_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      total_in     = total_ff;
      p_in         = p_ff;
      pslot_in     = pslot_ff;
      scan_up_in   = scan_up_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_data      = u_wdata;
      rd_addr      = slot_ff;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + SLOT_BITS'(1);
            if (clr_ff == SLOT_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_chan.valid) begin
               op_in    = req_chan.payload.op;
               value_in = req_chan.payload.value;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            state_in = S_MUL2;
         end
         S_MUL2: begin
            state_in = S_READ;
         end
         S_READ: begin
            rd_addr  = slot_calc;
            slot_in  = slot_calc;
            state_in = S_UPD;
         end
         S_UPD: begin
            if (u_scan) begin
               wr_en      = 1'b1;
               total_in   = u_total;
               scan_up_in = u_scan_up;
               p_in       = u_scan_up ? value_ff + 32'sd1 : value_ff - 32'sd1;
               pslot_in   = slot_next(slot_ff, u_scan_up);
               rd_addr    = slot_next(slot_ff, u_scan_up);
               state_in   = S_SCAN;
            end else if (out_free) begin
               wr_en                = u_wr;
               lo_in                = u_lo;
               hi_in                = u_hi;
               total_in             = u_total;
               rsp_valid_in         = 1'b1;
               rsp_in.ok            = u_ok;
               rsp_in.occurrences   = 16'(u_occ);
               rsp_in.total_held    = u_total;
               rsp_in.is_empty      = (u_total == '0);
               rsp_in.min_value     = u_lo;
               rsp_in.max_value     = u_hi;
               rsp_in.status        = u_status;
               req_ready            = 1'b1;
               if (req_chan.valid) begin
                  op_in    = req_chan.payload.op;
                  value_in = req_chan.payload.value;
                  state_in = S_MUL1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SCAN: begin
            rd_addr = slot_next(pslot_ff, scan_up_ff);
            if (scan_stop) begin
               if (scan_up_ff) begin
                  lo_in = p_ff;
               end else begin
                  hi_in = p_ff;
               end
               state_in = S_FIN;
            end else begin
               p_in     = scan_up_ff ? p_ff + 32'sd1 : p_ff - 32'sd1;
               pslot_in = slot_next(pslot_ff, scan_up_ff);
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.ok          = 1'b1;
               rsp_in.occurrences = '0;
               rsp_in.total_held  = total_ff;
               rsp_in.is_empty    = (total_ff == '0);
               rsp_in.min_value   = lo_ff;
               rsp_in.max_value   = hi_ff;
               rsp_in.status      = wmc_pkg::STATUS_OK;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      value_ff   <= value_in;
      quot_ff    <= quot_in;
      qd_ff      <= qd_in;
      slot_ff    <= slot_in;
      p_ff       <= p_in;
      pslot_ff   <= pslot_in;
      scan_up_ff <= scan_up_in;
      rsp_ff     <= rsp_in;
   end

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;
endmodule
